@@ src/ece_pkg.sv @@
// Package for the easing curve evaluator: default widths, curve codes and
// the Q16 fixed-point constants and table. No dependencies.
package ece_pkg;

  localparam int TIME_BITS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 16;

  // Fraction bits of the normalized time, one divider stage per bit
  localparam int FRAC_BITS = 16;
  localparam int SQRT_STEPS = 17;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  typedef enum logic [2:0] {
    CURVE_QUAD  = 3'd0,
    CURVE_QUINT = 3'd1,
    CURVE_CIRC  = 3'd2,
    CURVE_EXPO  = 3'd3,
    CURVE_CUBIC = 3'd4
  } curve_e;

  // 2^(-j/16) in Q16 for j = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] r;
    begin
      case (idx)
        5'd0:    r = 17'd65536;
        5'd1:    r = 17'd62757;
        5'd2:    r = 17'd60097;
        5'd3:    r = 17'd57549;
        5'd4:    r = 17'd55109;
        5'd5:    r = 17'd52773;
        5'd6:    r = 17'd50535;
        5'd7:    r = 17'd48393;
        5'd8:    r = 17'd46341;
        5'd9:    r = 17'd44376;
        5'd10:   r = 17'd42495;
        5'd11:   r = 17'd40693;
        5'd12:   r = 17'd38968;
        5'd13:   r = 17'd37316;
        5'd14:   r = 17'd35734;
        5'd15:   r = 17'd34219;
        5'd16:   r = 17'd32768;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ src/ece_if.sv @@
// Channel interfaces of the easing curve evaluator: sample input, result
// output and curve register write. Depends on nothing.
interface ece_in_if #(
  parameter int TIME_BITS  = 16,
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [TIME_BITS-1:0]  elapsed;
  logic [VALUE_BITS-1:0] start_value;
  logic [VALUE_BITS-1:0] change;
  logic [TIME_BITS-1:0]  duration;

  modport source (output valid, elapsed, start_value, change, duration, input ready);
  modport sink   (input valid, elapsed, start_value, change, duration, output ready);
endinterface

interface ece_out_if #(
  parameter int VALUE_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [VALUE_BITS:0] value;
  logic                finished;

  modport source (output valid, value, finished, input ready);
  modport sink   (input valid, value, finished, output ready);
endinterface

interface ece_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] curve_select;

  modport source (output valid, curve_select, input ready);
  modport sink   (input valid, curve_select, output ready);
endinterface

@@ src/ece_front.sv @@
// Front end: accepts samples, flags finished motions and tags each item
// with the active curve. Depends on ece_pkg and ece_if.
module ece_front import ece_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ItemW     = 4 + 2 * TIME_BITS + 2 * VALUE_BITS
) (
  ece_in_if.sink          in_i,
  input  curve_e          curve_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output logic [ItemW-1:0] push_data_o
);

  logic fin;

  // Classify: end of motion when the duration is zero or already reached
  assign fin = (in_i.duration == '0) || (in_i.elapsed >= in_i.duration);

  // Pass the handshake straight to the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign push_data_o  = {curve_i, fin, in_i.elapsed, in_i.duration,
                         in_i.start_value, in_i.change};

endmodule

@@ src/ece_fifo.sv @@
// Short item queue between front and back end.
// Depends on nothing.
module ece_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ src/ece_back.sv @@
// Back end: pipelined divider, curve multiply chain, square root, exponent
// table and final scaling. Depends on ece_pkg and ece_if.
module ece_back import ece_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ItemW     = 4 + 2 * TIME_BITS + 2 * VALUE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  logic [ItemW-1:0] pop_data_i,
  ece_out_if.source        out_o
);

  localparam int TB     = TIME_BITS;
  localparam int VB     = VALUE_BITS;
  localparam int PW     = VB + 18;
  localparam int PrepS  = FRAC_BITS;
  localparam int Mul0S  = PrepS + 1;
  localparam int Sqrt0S = Mul0S + 2;
  localparam int FselS  = Sqrt0S + SQRT_STEPS;
  localparam int ProdS  = FselS + 1;
  localparam int ResS   = ProdS + 1;
  localparam int NSt    = ResS + 1;

  typedef struct packed {
    logic [2:0]             sel;
    logic                   fin;
    logic [TB-1:0]          d;
    logic [TB-1:0]          r;
    logic [15:0]            q;
    logic signed [VB-1:0]   b;
    logic signed [VB-1:0]   c;
    logic                   first;
    logic [16:0]            w;
    logic [16:0]            p;
    logic [16:0]            m;
    logic [2:0]             n;
    logic [32:0]            sq;
    logic [32:0]            sx;
    logic [34:0]            sr;
    logic [3:0]             ek;
    logic [16:0]            ea;
    logic [16:0]            ediff;
    logic [11:0]            ef;
    logic [28:0]            eprod;
    logic [16:0]            g;
    logic [16:0]            f;
    logic signed [PW-1:0]   prod;
    logic signed [VB:0]     val;
  } work_t;

  work_t            st_q [NSt];
  work_t            st_d [NSt];
  logic [NSt-1:0]   vld_q;
  work_t            inj;
  logic             en;

  // One pipeline stage; the stage index picks its job
  function automatic work_t stage_fn(input int s, input work_t x);
    work_t              y;
    logic [TB:0]        r2;
    logic               ge;
    logic [16:0]        v;
    logic [19:0]        y10;
    logic [3:0]         idx;
    logic [33:0]        mp;
    logic [34:0]        bitv;
    logic [34:0]        sum;
    logic [17:0]        h;
    logic [17:0]        rnd;
    logic [17:0]        es;
    logic [28:0]        et;
    logic signed [PW-1:0] ce;
    logic signed [PW-1:0] fe;
    int                 j;
    begin
      y = x;
      // Restoring division, one quotient bit per stage
      if (s < PrepS) begin
        r2   = {x.r, 1'b0};
        ge   = (r2 >= {1'b0, x.d});
        y.q  = {x.q[14:0], ge};
        y.r  = ge ? TB'(r2 - {1'b0, x.d}) : TB'(r2);
      end
      // Fold the time to the nearer end and set up the multiply chain
      if (s == PrepS) begin
        v       = ONE_Q16 - {1'b0, x.q};
        y.first = !x.q[15];
        y.w     = y.first ? {x.q, 1'b0} : 17'(v << 1);
        y10     = {x.q, 4'b0000} - {x.q, 2'b00} - {x.q, 1'b0};
        idx     = y10[15:12];
        y.ek    = y10[19:16];
        y.ef    = y10[11:0];
        y.ea    = pow2_neg({1'b0, idx});
        y.ediff = y.ea - pow2_neg(5'({1'b0, idx}) + 5'd1);
        unique case (curve_e'(x.sel))
          CURVE_QUAD: begin
            y.p = y.w;
            y.m = y.w >> 1;
            y.n = 3'd1;
          end
          CURVE_CUBIC: begin
            y.p = v;
            y.m = v;
            y.n = 3'd2;
          end
          CURVE_CIRC, CURVE_EXPO: begin
            y.p = y.w;
            y.m = y.w;
            y.n = 3'd0;
          end
          default: begin
            y.p = y.w;
            y.m = y.w;
            y.n = 3'd4;
          end
        endcase
      end
      // Rounded Q16 products, as many as the curve needs
      if (s >= Mul0S && s < Mul0S + 4 && (s - Mul0S) < int'(x.n)) begin
        mp  = 34'(x.p) * 34'(x.m) + 34'(HALF_Q16);
        y.p = mp[32:16];
      end
      if (s == Mul0S) begin
        mp      = 34'(x.w) * 34'(x.w);
        y.sq    = mp[32:0];
        y.eprod = 29'(x.ediff) * 29'(x.ef);
      end
      if (s == Mul0S + 1) begin
        y.sx = 33'h1_0000_0000 - x.sq;
        y.sr = '0;
        et   = x.eprod + 29'd2048;
        y.ea = x.ea - 17'(et >> 12);
      end
      // Scale the power of two down by the integer part, rounded
      if (s == Mul0S + 2) begin
        rnd = (x.ek == 4'd0) ? 18'd0 : (18'd1 << (x.ek - 4'd1));
        es  = 18'(x.ea) + rnd;
        y.g = 17'(es >> x.ek);
      end
      // Integer square root, one result bit per stage
      if (s >= Sqrt0S && s < FselS) begin
        j    = s - Sqrt0S;
        bitv = 35'd1 << (2 * (SQRT_STEPS - 1 - j));
        sum  = x.sr + bitv;
        if (35'(x.sx) >= sum) begin
          y.sx = 33'(35'(x.sx) - sum);
          y.sr = (x.sr >> 1) + bitv;
        end else begin
          y.sr = x.sr >> 1;
        end
      end
      // Pick the curve factor
      if (s == FselS) begin
        unique case (curve_e'(x.sel))
          CURVE_QUAD: begin
            y.f = x.first ? x.p : ONE_Q16 - x.p;
          end
          CURVE_CIRC: begin
            h   = (18'(ONE_Q16) - 18'(x.sr[16:0]) + 18'd1) >> 1;
            y.f = x.first ? h[16:0] : ONE_Q16 - h[16:0];
          end
          CURVE_EXPO: begin
            y.f = ONE_Q16 - x.g;
          end
          CURVE_CUBIC: begin
            y.f = ONE_Q16 - x.p;
          end
          default: begin
            h   = (18'(x.p) + 18'd1) >> 1;
            y.f = x.first ? h[16:0] : ONE_Q16 - h[16:0];
          end
        endcase
      end
      if (s == ProdS) begin
        ce     = PW'(x.c);
        fe     = PW'($signed({1'b0, x.f}));
        y.prod = ce * fe + PW'(32'sd32768);
      end
      if (s == ResS) begin
        if (x.fin) begin
          y.val = (VB + 1)'(x.b) + (VB + 1)'(x.c);
        end else begin
          y.val = (VB + 1)'(x.b) + (VB + 1)'(x.prod >>> 16);
        end
      end
      return y;
    end
  endfunction

  // Unpack the queue head into a fresh work item
  always_comb begin
    inj      = '0;
    inj.sel  = pop_data_i[ItemW-1 -: 3];
    inj.fin  = pop_data_i[ItemW-4];
    inj.r    = pop_data_i[ItemW-5 -: TB];
    inj.d    = pop_data_i[ItemW-5-TB -: TB];
    inj.b    = pop_data_i[2*VB-1 -: VB];
    inj.c    = pop_data_i[VB-1:0];
  end

  // Advance the whole pipe unless the output holds an untaken result
  assign en          = !vld_q[NSt-1] || out_o.ready;
  assign pop_ready_o = en;

  always_comb begin
    for (int s = 0; s < NSt; s++) begin
      if (s == 0) begin
        st_d[s] = stage_fn(s, inj);
      end else begin
        st_d[s] = stage_fn(s, st_q[s-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSt-2:0], pop_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NSt; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign out_o.valid    = vld_q[NSt-1];
  assign out_o.value    = st_q[NSt-1].val;
  assign out_o.finished = st_q[NSt-1].fin;

endmodule

@@ src/easing_curve_evaluator.sv @@
// Top level of the easing curve evaluator: curve register, front end, item
// queue and back-end pipeline. Depends on ece_pkg, ece_if and submodules.
//
// Usage:
//   in_i   carries one sample point per item: elapsed, start_value, change
//          and duration. out_o returns one item each: the eased value and a
//          finished flag. cfg_i writes the 3-bit curve select; the user is to write it
//          only while the block is idle, not enforced by it; cfg_i is always ready.
//   Throughput is one item per cycle while out_o is not stalled. After input
//   acceptance an item reaches out_o via the queue write, then a 39-stage
//   pipe whose first stage loads on the edge that pops the queue (16
//   divider stages, a fold and two multiply and exponent stages, 17
//   square-root stages, then curve selection, scaling and the sum).
//   Reset empties the queue and the pipe and sets the curve to quintic.
//   When the receiver stalls, the whole pipe holds and the result stays on
//   out_o; the two-entry queue keeps taking input until it fills, after
//   which in_i.ready drops.
module easing_curve_evaluator import ece_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ece_in_if.sink    in_i,
  ece_out_if.source out_o,
  ece_cfg_if.sink   cfg_i
);

  localparam int ItemW = 4 + 2 * TIME_BITS + 2 * VALUE_BITS;

  curve_e           curve_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [ItemW-1:0] push_data, pop_data;

  // Curve select register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= CURVE_QUINT;
    end else if (cfg_i.valid) begin
      curve_q <= curve_e'(cfg_i.curve_select);
    end
  end

  ece_front #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_i         (in_i),
    .curve_i      (curve_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ece_fifo #(
    .WIDTH (ItemW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ece_back #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

  // A stalled result freezes the pipe, so nothing leaves the queue
  a_stall_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !(pop_valid && pop_ready))
    else $error("queue popped while output stalled");

  // After a push into the queue, the queue is non-empty in the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready) |=> pop_valid)
    else $error("queue lost a pushed item");

  // Input is accepted exactly when the queue takes it
  a_in_to_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (push_valid && push_ready))
    else $error("input accepted without a queue push");

endmodule

@@ dv/tb.sv @@
// Testbench for easing_curve_evaluator: random and directed sample points,
// checked against a fixed-point curve predictor. Needs ece_pkg and ece_if.
`timescale 1ns / 100ps

module tb;
  import ece_pkg::*;

  localparam logic [2:0] CURVE_SPARE_LO = 3'd5;
  localparam logic [2:0] CURVE_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 50;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic [15:0] elapsed;
    logic [15:0] start_value;
    logic [15:0] change;
    logic [15:0] duration;
  } sample_t;

  typedef struct packed {
    logic [16:0] value;
    logic        finished;
  } eased_t;

  logic clk_i;
  logic rst_ni;

  ece_in_if  #(.TIME_BITS(16), .VALUE_BITS(16)) in_if ();
  ece_out_if #(.VALUE_BITS(16)) out_if ();
  ece_cfg_if cfg_if ();

  easing_curve_evaluator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  sample_t     pending_q[$];
  eased_t      eased_q[$];
  logic [2:0]  active_curve;
  int          send_gap;
  int          recv_gap;
  bit          send_steady;
  bit          recv_steady;
  int          errors;
  int          quiet_cycles;

  // 2^(-j/16) in Q16
  longint unsigned exp_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                   48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                   35734, 34219, 32768};

  function automatic longint unsigned qmul16(longint unsigned a, longint unsigned b);
    return (a * b + 32768) >> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Curve factor in Q1.16 at normalized time u (Q0.16)
  function automatic longint unsigned curve_factor(longint unsigned u, logic [2:0] sel);
    longint unsigned v, w, p, s, h, y, r, fr, a, b, e, g;
    int k, idx;
    bit first;
    v = 65536 - u;
    first = u < 32768;
    w = first ? 2 * u : 2 * v;
    case (sel)
      CURVE_QUAD: begin
        if (first) return (2 * u * u + 32768) >> 16;
        return 65536 - ((2 * v * v + 32768) >> 16);
      end
      CURVE_CIRC: begin
        s = root_floor((64'd1 << 32) - w * w);
        h = (65536 - s + 1) >> 1;
        return first ? h : 65536 - h;
      end
      CURVE_EXPO: begin
        y = 10 * u;
        k = int'(y >> 16) & 15;
        r = y & 64'hFFFF;
        idx = int'(r >> 12) & 15;
        fr = r & 64'hFFF;
        a = exp_tab[idx];
        b = exp_tab[idx + 1];
        e = a - (((a - b) * fr + 2048) >> 12);
        g = (k > 0) ? ((e + (64'd1 << (k - 1))) >> k) : e;
        return 65536 - g;
      end
      CURVE_CUBIC: return 65536 - qmul16(qmul16(v, v), v);
      default: begin
        p = w;
        repeat (4) p = qmul16(p, w);
        p = (p + 1) >> 1;
        return first ? p : 65536 - p;
      end
    endcase
  endfunction

  function automatic eased_t ease_sample(sample_t smp, logic [2:0] sel);
    eased_t res;
    longint sv, ch, sum, x;
    longint unsigned u;
    sv = longint'($signed(smp.start_value));
    ch = longint'($signed(smp.change));
    if (smp.duration == 0 || smp.elapsed >= smp.duration) begin
      sum = sv + ch;
      res.finished = 1'b1;
    end else begin
      u = (longint'(smp.elapsed) << 16) / longint'(smp.duration);
      x = ch * longint'(curve_factor(u, sel)) + 32768;
      sum = sv + (x >>> 16);
      res.finished = 1'b0;
    end
    res.value = sum[16:0];
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic sample_t random_sample();
    sample_t smp;
    int roll;
    smp.start_value = 16'($urandom);
    smp.change = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 5) smp.duration = '0;
    else if (roll < 35) smp.duration = 16'($urandom_range(1, 16));
    else smp.duration = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (smp.duration != 0 && roll < 80)
      smp.elapsed = 16'($urandom_range(0, smp.duration - 1));
    else if (roll < 90)
      smp.elapsed = smp.duration;
    else
      smp.elapsed = 16'($urandom);
    return smp;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample driver: present the head of the pending queue, hold under backpressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        eased_q.push_back(ease_sample(pending_q.pop_front(), active_curve));
        send_gap = send_steady ? 0 : pick_gap();
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_if.valid       <= 1'b1;
          in_if.elapsed     <= pending_q[0].elapsed;
          in_if.start_value <= pending_q[0].start_value;
          in_if.change      <= pending_q[0].change;
          in_if.duration    <= pending_q[0].duration;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest expectation
  always @(posedge clk_i) begin
    eased_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (eased_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%0d finished=%0b", $time,
                   $signed(out_if.value), out_if.finished);
        end else begin
          want = eased_q.pop_front();
          if (out_if.value !== want.value) begin
            errors++;
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(want.value), $signed(out_if.value));
          end
          if (out_if.finished !== want.finished) begin
            errors++;
            $display("%0t: finished expected %0b actual %0b", $time,
                     want.finished, out_if.finished);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_gap = recv_steady ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_curve(input logic [2:0] sel);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.curve_select <= sel;
    do @(posedge clk_i); while (!cfg_if.ready);
    active_curve = sel;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && eased_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] el, input logic [15:0] sv,
                             input logic [15:0] ch, input logic [15:0] du);
    sample_t smp;
    smp.elapsed = el;
    smp.start_value = sv;
    smp.change = ch;
    smp.duration = du;
    pending_q.push_back(smp);
  endtask

  // Stimulus: one phase per entry of phase_curve, default curve first
  initial begin
    logic [2:0] phase_curve[9];
    phase_curve = '{CURVE_QUINT, CURVE_QUAD, CURVE_CIRC, CURVE_EXPO, CURVE_CUBIC,
                    CURVE_SPARE_LO, 3'd6, CURVE_SPARE_HI, CURVE_QUAD};
    errors = 0;
    quiet_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    send_steady = 0;
    recv_steady = 0;
    active_curve = CURVE_QUINT;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.elapsed = '0;
    in_if.start_value = '0;
    in_if.change = '0;
    in_if.duration = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.curve_select = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (phase_curve[ph]) begin
      if (ph > 0) write_curve(phase_curve[ph]);
      // Edge cases: zero duration, end of motion, halfway point, extremes
      push_sample(16'd0, 16'h8000, 16'h8000, 16'd0);
      push_sample(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      push_sample(16'd5, 16'h7FFF, 16'h8000, 16'd3);
      push_sample(16'd0, 16'h1234, 16'h7FFF, 16'hFFFF);
      push_sample(16'hFFFE, 16'h8000, 16'h7FFF, 16'hFFFF);
      push_sample(16'd1, 16'd0, 16'h8000, 16'd2);
      push_sample(16'd32767, 16'hFFFF, 16'h7FFF, 16'hFFFF);
      push_sample(16'd32768, 16'd0, 16'h8000, 16'hFFFF);
      push_sample(16'd1, 16'h0001, 16'hFFFF, 16'd1);
      send_steady = (ph % 3 == 1);
      recv_steady = (ph % 3 == 2);
      repeat (95) pending_q.push_back(random_sample());
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
